// ----- rtl/ancm_pkg.sv -----
// ancm_pkg: shared types, constants and helper functions for the ANSI-16
// nearest colour match block. No dependencies.
package ancm_pkg;

   localparam int NUM_SYS_COLOURS = 16;
   localparam int DIST_WIDTH      = 18;

   localparam logic [1:0] KIND_DEFAULT = 2'd0;
   localparam logic [1:0] KIND_RGB     = 2'd1;
   localparam logic [1:0] KIND_INDEXED = 2'd2;

   localparam logic [7:0] GREY_START   = 8'd232;
   localparam logic [7:0] CUBE_START   = 8'd16;

   localparam logic [23:0] SYS_RGB [NUM_SYS_COLOURS] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
      24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };

   typedef struct packed {
      logic [1:0]  colour_kind;
      logic [23:0] rgb_value;
      logic [7:0]  palette_index;
      logic        role_present;
      logic [3:0]  role_code;
   } ancm_req_type;

   typedef struct packed {
      logic       result_valid;
      logic [3:0] system_index;
   } ancm_rsp_type;

   // data handed from cell to cell
   typedef struct packed {
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [DIST_WIDTH-1:0] best_dist;
      logic [3:0]            best_index;
      logic                  decided;
      ancm_rsp_type          decided_rsp;
   } ancm_carry_type;

   function automatic logic [7:0] ancm_cube_level(input logic [2:0] lv);
      logic [7:0] level;
      if (lv == 3'd0) begin
         level = 8'd0;
      end else begin
         level = 8'(8'd55 + {5'd0, lv} * 8'd40);
      end
      return level;
   endfunction

   // palette index 16..255 to RGB; x/36 and x/6 by reciprocal multiply
   function automatic logic [23:0] ancm_expand_index(input logic [7:0] idx);
      logic [7:0]  x;
      logic [13:0] prod_r;
      logic [2:0]  lv_r;
      logic [5:0]  rem;
      logic [11:0] prod_g;
      logic [2:0]  lv_g;
      logic [2:0]  lv_b;
      logic [7:0]  grey;
      logic [23:0] rgb;
      x      = 8'(idx - CUBE_START);
      prod_r = 14'(x) * 14'd57;
      lv_r   = prod_r[13:11];
      rem    = 6'(x - 8'({5'd0, lv_r} * 8'd36));
      prod_g = 12'(rem) * 12'd43;
      lv_g   = prod_g[10:8];
      lv_b   = 3'(rem - 6'({3'd0, lv_g} * 6'd6));
      grey   = 8'(8'd8 + 8'(idx - GREY_START) * 8'd10);
      if (idx >= GREY_START) begin
         rgb = {grey, grey, grey};
      end else begin
         rgb = {ancm_cube_level(lv_r), ancm_cube_level(lv_g), ancm_cube_level(lv_b)};
      end
      return rgb;
   endfunction

endpackage

// ----- rtl/ancm_front.sv -----
// ancm_front: entry stage; decodes the colour kind, settles pass-through
// cases and expands palette indexes to RGB. Depends on ancm_pkg.
module ancm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  ancm_pkg::ancm_req_type  up_data,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output ancm_pkg::ancm_carry_type dn_data
);
   import ancm_pkg::*;

   logic           valid_ff, valid_in;
   ancm_carry_type data_ff, data_in;
   logic [23:0]    rgb;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      data_in                  = '0;
      data_in.best_dist        = '1;
      rgb                      = ancm_expand_index(up_data.palette_index);
      unique case (up_data.colour_kind)
         KIND_RGB: begin
            rgb = up_data.rgb_value;
            if (up_data.role_present) begin
               data_in.decided     = 1'b1;
               data_in.decided_rsp = '{result_valid: 1'b1,
                                       system_index: up_data.role_code};
            end
         end
         KIND_INDEXED: begin
            if (up_data.role_present) begin
               data_in.decided     = 1'b1;
               data_in.decided_rsp = '{result_valid: 1'b1,
                                       system_index: up_data.role_code};
            end else if (up_data.palette_index < CUBE_START) begin
               data_in.decided     = 1'b1;
               data_in.decided_rsp = '{result_valid: 1'b1,
                                       system_index: up_data.palette_index[3:0]};
            end
         end
         default: begin
            data_in.decided     = 1'b1;
            data_in.decided_rsp = '0;
         end
      endcase
      data_in.red   = rgb[23:16];
      data_in.green = rgb[15:8];
      data_in.blue  = rgb[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- rtl/ancm_cell.sv -----
// ancm_cell: one comparison cell; squared RGB distance to one system colour,
// keeps the nearer of it and the running best. Depends on ancm_pkg.
module ancm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  ancm_pkg::ancm_carry_type up_data,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output ancm_pkg::ancm_carry_type dn_data
);
   import ancm_pkg::*;

   localparam logic [23:0] SYS_COLOUR = SYS_RGB[CELL_INDEX];

   logic                  valid_ff, valid_in;
   ancm_carry_type        data_ff, data_in;
   logic signed [8:0]     diff_r, diff_g, diff_b;
   logic signed [17:0]    prod_r, prod_g, prod_b;
   logic [DIST_WIDTH-1:0] sq_dist;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      diff_r  = $signed({1'b0, SYS_COLOUR[23:16]}) - $signed({1'b0, up_data.red});
      diff_g  = $signed({1'b0, SYS_COLOUR[15:8]}) - $signed({1'b0, up_data.green});
      diff_b  = $signed({1'b0, SYS_COLOUR[7:0]}) - $signed({1'b0, up_data.blue});
      prod_r  = diff_r * diff_r;
      prod_g  = diff_g * diff_g;
      prod_b  = diff_b * diff_b;
      sq_dist = DIST_WIDTH'(prod_r[15:0]) + DIST_WIDTH'(prod_g[15:0])
              + DIST_WIDTH'(prod_b[15:0]);
      data_in = up_data;
      // strict compare: lower index wins a tie
      if (sq_dist < up_data.best_dist) begin
         data_in.best_dist  = sq_dist;
         data_in.best_index = 4'(CELL_INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ----- rtl/ansi16_nearest_colour_match_top.sv -----
// ansi16_nearest_colour_match_top: front stage, a chain of 16 compare cells
// and the response register. Depends on ancm_pkg, ancm_front, ancm_cell.
// Registers from request accept to rsp_valid: 18 (front, 16 cells, output;
// the front loads at the accept edge).
// Throughput: one request per cycle while the response side does not stall;
// each stage holds one request and the chain closes bubbles when it stalls.
// Reset: synchronous; clears all stage valid bits, no other state.
module ansi16_nearest_colour_match_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ancm_pkg::ancm_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ancm_pkg::ancm_rsp_type rsp_data
);
   import ancm_pkg::*;

   logic           link_valid [NUM_SYS_COLOURS+1];
   logic           link_ready [NUM_SYS_COLOURS+1];
   ancm_carry_type link_data  [NUM_SYS_COLOURS+1];

   logic           rsp_valid_ff, rsp_valid_in;
   ancm_rsp_type   rsp_data_ff, rsp_data_in;
   logic           last_ready;

   ancm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_data),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0]),
      .dn_data  (link_data[0])
   );

   for (genvar i = 0; i < NUM_SYS_COLOURS; i++) begin : g_cell
      ancm_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_data  (link_data[i]),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_data  (link_data[i+1])
      );
   end

   assign last_ready                  = !rsp_valid_ff || rsp_ready;
   assign link_ready[NUM_SYS_COLOURS] = last_ready;
   assign rsp_valid_in = last_ready ? link_valid[NUM_SYS_COLOURS] : rsp_valid_ff;

   always_comb begin
      if (link_data[NUM_SYS_COLOURS].decided) begin
         rsp_data_in = link_data[NUM_SYS_COLOURS].decided_rsp;
      end else begin
         rsp_data_in = '{result_valid: 1'b1,
                         system_index: link_data[NUM_SYS_COLOURS].best_index};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_ready && link_valid[NUM_SYS_COLOURS]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- dv/ansi16_nearest_colour_match_top_test.sv -----
// Testbench for ansi16_nearest_colour_match_top: drives colour requests, predicts the
// matching system colour index and checks every response in order.
// Depends on ancm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module ansi16_nearest_colour_match_top_test;
   import ancm_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;

   localparam logic [23:0] SYSTEM_PALETTE [16] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
      24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };

   localparam logic [7:0] TIE_LEVELS [8] = '{
      8'h00, 8'h40, 8'h60, 8'h80, 8'hA0, 8'hC0, 8'hE0, 8'hFF
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   ancm_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   ancm_rsp_type rsp_data;

   ancm_rsp_type expected_matches[$];
   int           error_count;
   int           cycle_count;
   bit           sender_idles;
   bit           receiver_idles;
   bit           long_hold;

   ansi16_nearest_colour_match_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [7:0] cube_step(input int lv);
      return (lv == 0) ? 8'd0 : 8'(55 + 40 * lv);
   endfunction

   function automatic logic [23:0] palette_to_rgb(input logic [7:0] idx);
      int n;
      logic [7:0] grey;
      if (idx >= 8'd232) begin
         grey = 8'(8 + (int'(idx) - 232) * 10);
         return {grey, grey, grey};
      end
      n = int'(idx) - 16;
      return {cube_step(n / 36), cube_step((n / 6) % 6), cube_step(n % 6)};
   endfunction

   function automatic logic [3:0] closest_system(input logic [23:0] c);
      int best_d;
      int d;
      int dr;
      int dg;
      int db;
      logic [3:0] best;
      best_d = 32'h7FFFFFFF;
      best = 4'd0;
      for (int i = 0; i < 16; i++) begin
         dr = int'({24'd0, SYSTEM_PALETTE[i][23:16]}) - int'({24'd0, c[23:16]});
         dg = int'({24'd0, SYSTEM_PALETTE[i][15:8]}) - int'({24'd0, c[15:8]});
         db = int'({24'd0, SYSTEM_PALETTE[i][7:0]}) - int'({24'd0, c[7:0]});
         d = dr * dr + dg * dg + db * db;
         if (d < best_d) begin
            best_d = d;
            best = 4'(i);
         end
      end
      return best;
   endfunction

   function automatic ancm_rsp_type colour_match(input ancm_req_type r);
      ancm_rsp_type m;
      m = '0;
      if (r.colour_kind == KIND_DEFAULT || r.colour_kind == KIND_UNUSED) begin
         return m;
      end
      m.result_valid = 1'b1;
      if (r.role_present) begin
         m.system_index = r.role_code;
      end else if (r.colour_kind == KIND_INDEXED && r.palette_index < 8'd16) begin
         m.system_index = r.palette_index[3:0];
      end else if (r.colour_kind == KIND_RGB) begin
         m.system_index = closest_system(r.rgb_value);
      end else begin
         m.system_index = closest_system(palette_to_rgb(r.palette_index));
      end
      return m;
   endfunction

   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic ancm_req_type random_colour();
      ancm_req_type r;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         r.colour_kind = KIND_DEFAULT;
      end else if (roll < 12) begin
         r.colour_kind = KIND_UNUSED;
      end else if (roll < 56) begin
         r.colour_kind = KIND_RGB;
      end else begin
         r.colour_kind = KIND_INDEXED;
      end
      if ($urandom_range(0, 9) < 3) begin
         r.rgb_value = {TIE_LEVELS[$urandom_range(0, 7)], TIE_LEVELS[$urandom_range(0, 7)],
                        TIE_LEVELS[$urandom_range(0, 7)]};
      end else begin
         r.rgb_value = 24'($urandom);
      end
      r.palette_index = 8'($urandom);
      r.role_present = ($urandom_range(0, 3) == 0);
      r.role_code = 4'($urandom);
      return r;
   endfunction

   task automatic send_colour(input ancm_req_type item);
      int gap;
      gap = pick_gap(sender_idles);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         req_data = random_colour();
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (!req_ready);
      expected_matches.push_back(colour_match(item));
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [23:0] rgb,
                              input logic [7:0] idx, input logic rp, input logic [3:0] role);
      ancm_req_type r;
      r.colour_kind = kind;
      r.rgb_value = rgb;
      r.palette_index = idx;
      r.role_present = rp;
      r.role_code = role;
      send_colour(r);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      send_fields(KIND_DEFAULT, 24'hFFFFFF, 8'hFF, 1'b0, 4'hF);
      send_fields(KIND_DEFAULT, 24'h123456, 8'd20, 1'b1, 4'd9);
      send_fields(KIND_UNUSED, 24'hFFFFFF, 8'd200, 1'b1, 4'hF);
      send_fields(KIND_RGB, 24'h000000, 8'd0, 1'b0, 4'd0);
      send_fields(KIND_RGB, 24'hFFFFFF, 8'd0, 1'b0, 4'd0);
      send_fields(KIND_RGB, 24'h400000, 8'd0, 1'b0, 4'd0);
      send_fields(KIND_RGB, 24'hE0E0E0, 8'd0, 1'b0, 4'd0);
      send_fields(KIND_RGB, 24'hA0A0A0, 8'd0, 1'b0, 4'd0);
      send_fields(KIND_RGB, 24'h606060, 8'd0, 1'b0, 4'd0);
      send_fields(KIND_RGB, 24'h00FFFF, 8'd0, 1'b1, 4'd0);
      send_fields(KIND_RGB, 24'h000000, 8'd0, 1'b1, 4'd15);
      send_fields(KIND_INDEXED, 24'hFFFFFF, 8'd0, 1'b0, 4'd0);
      send_fields(KIND_INDEXED, 24'h000000, 8'd15, 1'b0, 4'd0);
      send_fields(KIND_INDEXED, 24'h000000, 8'd16, 1'b0, 4'd0);
      send_fields(KIND_INDEXED, 24'h000000, 8'd231, 1'b0, 4'd0);
      send_fields(KIND_INDEXED, 24'h000000, 8'd232, 1'b0, 4'd0);
      send_fields(KIND_INDEXED, 24'h000000, 8'd255, 1'b0, 4'd0);
      send_fields(KIND_INDEXED, 24'h000000, 8'd244, 1'b0, 4'd0);
      send_fields(KIND_INDEXED, 24'h000000, 8'd7, 1'b1, 4'd12);
      send_fields(KIND_INDEXED, 24'h000000, 8'd100, 1'b1, 4'd3);
      for (int i = 0; i < 16; i++) begin
         send_fields(KIND_RGB, SYSTEM_PALETTE[i], 8'd0, 1'b0, 4'd0);
      end
      wait_for_drain();
   endtask

   task automatic test_random_colours(input int count, input bit tx_idle, input bit rx_idle);
      sender_idles = tx_idle;
      receiver_idles = rx_idle;
      repeat (count) send_colour(random_colour());
      wait_for_drain();
   endtask

   task automatic test_response_backpressure();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      @(negedge clock);
      long_hold = 1'b1;
      repeat (100) send_colour(random_colour());
      wait_for_drain();
   endtask

   // receiver: random stalls, plus one long hold on request
   initial begin
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            n = pick_gap(1'b1);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      ancm_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $error("unexpected response result_valid %0d system_index %0d",
                   rsp_data.result_valid, rsp_data.system_index);
            error_count++;
         end else begin
            want = expected_matches.pop_front();
            if (rsp_data.result_valid !== want.result_valid) begin
               $error("result_valid expected %0d actual %0d",
                      want.result_valid, rsp_data.result_valid);
               error_count++;
            end
            if (rsp_data.system_index !== want.system_index) begin
               $error("system_index expected %0d actual %0d",
                      want.system_index, rsp_data.system_index);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      error_count = 0;
      cycle_count = 0;
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      long_hold = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_colours(500, 1'b1, 1'b1);
      test_random_colours(500, 1'b0, 1'b0);
      test_response_backpressure();
      test_random_colours(450, 1'b1, 1'b0);
      test_random_colours(450, 1'b0, 1'b1);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_matches.size() != 0) begin
         $error("%0d responses never arrived", expected_matches.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
